### hdl/bbr_pkg.sv
// Shared types and constants for the 5x5 RGB box mean filter.
package bbr_pkg;

    localparam int WIN       = 5;
    localparam int LINES     = WIN - 1;
    localparam int CH_W      = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 1024;
    localparam int COLSUM_W  = 11;
    localparam int WINSUM_W  = 13;
    localparam int DIV_MUL_W = 13;
    localparam int PROD_W    = WINSUM_W + DIV_MUL_W;
    localparam int DIV_SHIFT = 17;

    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 13'd5243;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef pixel_t [LINES-1:0] line_col_t;
    typedef pixel_t [WIN-1:0]   column_t;

    typedef struct packed {
        logic [WINSUM_W-1:0] red;
        logic [WINSUM_W-1:0] green;
        logic [WINSUM_W-1:0] blue;
    } win_sum_t;

endpackage

### hdl/bbr_line_buffer.sv
// Line memory holding four previous image lines, one packed column per address.
module bbr_line_buffer #(
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  bbr_pkg::line_col_t wr_data,
    output bbr_pkg::line_col_t rd_data
);
    import bbr_pkg::*;

    line_col_t mem [DEPTH];
    line_col_t rd_q_reg;
    line_col_t fwd_reg;
    logic      fwd_sel_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // bypass a write that hits the address being read in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_reg     <= wr_data;
            fwd_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_sel_reg ? fwd_reg : rd_q_reg;

endmodule

### hdl/bbr_window.sv
// 5x5 window sums built from the incoming column and four held column sums per channel.
module bbr_window (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  bbr_pkg::column_t col_in,
    output bbr_pkg::win_sum_t win_sum
);
    import bbr_pkg::*;

    typedef struct packed {
        logic [COLSUM_W-1:0] red;
        logic [COLSUM_W-1:0] green;
        logic [COLSUM_W-1:0] blue;
    } colsum_t;

    colsum_t  cs_reg [WIN-1];
    colsum_t  cs_new;
    win_sum_t win_sum_reg;
    win_sum_t win_sum_next;

    always_comb begin
        cs_new = '0;
        for (int r = 0; r < WIN; r++) begin
            cs_new.red   = cs_new.red   + COLSUM_W'(col_in[r].red);
            cs_new.green = cs_new.green + COLSUM_W'(col_in[r].green);
            cs_new.blue  = cs_new.blue  + COLSUM_W'(col_in[r].blue);
        end
        win_sum_next.red   = WINSUM_W'(cs_new.red);
        win_sum_next.green = WINSUM_W'(cs_new.green);
        win_sum_next.blue  = WINSUM_W'(cs_new.blue);
        for (int c = 0; c < WIN - 1; c++) begin
            win_sum_next.red   = win_sum_next.red   + WINSUM_W'(cs_reg[c].red);
            win_sum_next.green = win_sum_next.green + WINSUM_W'(cs_reg[c].green);
            win_sum_next.blue  = win_sum_next.blue  + WINSUM_W'(cs_reg[c].blue);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < WIN - 1; c++) begin
                cs_reg[c] <= '0;
            end
            win_sum_reg <= '0;
        end else if (shift_en) begin
            for (int c = 0; c < WIN - 2; c++) begin
                cs_reg[c] <= cs_reg[c+1];
            end
            cs_reg[WIN-2] <= cs_new;
            win_sum_reg   <= win_sum_next;
        end
    end

    assign win_sum = win_sum_reg;

endmodule

### hdl/box_blur_5x5_rgb_top.sv
// Results pass the stage 1 register, the stage 2 window sums and the output registers.
// Throughput: one pixel per clock unless the m_ channel stalls; the line memory is read
// and written once per pixel. The only stall source is back-pressure on the m_ channel.
// Reset (synchronous, active low) clears counters, window sums and stage valids, and
// sets line_width to 1024; the line memory is not cleared.
module box_blur_5x5_rgb_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_line_width,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic        s_frame_start,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_mean_red,
    output logic [7:0]  m_mean_green,
    output logic [7:0]  m_mean_blue,
    output logic        m_window_valid
);
    import bbr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CMP_W-1:0] W_MIN   = CMP_W'(WIN);
    localparam logic [CMP_W-1:0] W_MAX   = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] W_RESET =
        CMP_W'((MAX_WIDTH < CFG_RESET) ? MAX_WIDTH : CFG_RESET);
    localparam logic [2:0]       ROW_MAX = 3'(LINES);
    localparam logic [COL_W-1:0] COL_MIN = COL_W'(LINES);

    logic [CMP_W-1:0] width_reg;
    logic [CMP_W-1:0] width_next;
    logic [CMP_W-1:0] lw_ext;

    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [2:0]       row_count_reg;
    logic [2:0]       row_count_next;
    logic [COL_W-1:0] col_cur;
    logic [2:0]       row_cur;
    logic [CMP_W-1:0] col_inc;
    logic             line_end;
    logic             win_ok;

    logic             s_fire;
    logic             st1_valid_reg;
    logic             st1_win_ok_reg;
    pixel_t           st1_pix_reg;
    logic [COL_W-1:0] st1_col_reg;
    logic             st1_fire;

    logic             st2_valid_reg;
    logic             st2_win_ok_reg;
    logic             st2_ready;
    logic             st2_fire;

    logic             out_free;
    logic             m_valid_reg;
    logic             m_window_valid_reg;
    logic [7:0]       m_mean_red_reg;
    logic [7:0]       m_mean_green_reg;
    logic [7:0]       m_mean_blue_reg;

    line_col_t        line_rd;
    line_col_t        line_wr;
    column_t          column;
    win_sum_t         win_sum;
    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_blue;

    // handshake chain
    assign out_free  = !m_valid_reg || m_ready;
    assign st2_fire  = st2_valid_reg && out_free;
    assign st2_ready = !st2_valid_reg || st2_fire;
    assign st1_fire  = st1_valid_reg && st2_ready;
    assign s_ready   = !st1_valid_reg || st1_fire;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration: store the clamped width
    always_comb begin
        lw_ext = CMP_W'(cfg_line_width);
        if (lw_ext < W_MIN) begin
            width_next = W_MIN;
        end else if (lw_ext > W_MAX) begin
            width_next = W_MAX;
        end else begin
            width_next = lw_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= W_RESET;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= width_next;
        end
    end

    // position tracking
    always_comb begin
        col_cur  = s_frame_start ? '0 : column_count_reg;
        row_cur  = s_frame_start ? '0 : row_count_reg;
        col_inc  = CMP_W'(col_cur) + CMP_W'(1);
        line_end = col_inc >= width_reg;
        win_ok   = (row_cur >= ROW_MAX) && (col_cur >= COL_MIN);
        column_count_next = line_end ? '0 : col_inc[COL_W-1:0];
        row_count_next    = (line_end && (row_cur < ROW_MAX)) ? row_cur + 3'd1 : row_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (s_fire) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // stage 1: pixel waits for the line memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_pix_reg    <= '{red: s_red, green: s_green, blue: s_blue};
            st1_col_reg    <= col_cur;
            st1_win_ok_reg <= win_ok;
        end
    end

    bbr_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (col_cur),
        .wr_en   (st1_fire),
        .wr_addr (st1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // oldest line first, current pixel last
    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            column[r] = line_rd[r];
        end
        column[LINES] = st1_pix_reg;
        for (int r = 0; r < LINES; r++) begin
            line_wr[r] = column[r+1];
        end
    end

    bbr_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (st1_fire),
        .col_in   (column),
        .win_sum  (win_sum)
    );

    // stage 2: window sums held in the window unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (st2_ready) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_fire) begin
            st2_win_ok_reg <= st1_win_ok_reg;
        end
    end

    // divide by 25 through a reciprocal multiply
    assign prod_red   = PROD_W'(win_sum.red)   * PROD_W'(DIV_MUL);
    assign prod_green = PROD_W'(win_sum.green) * PROD_W'(DIV_MUL);
    assign prod_blue  = PROD_W'(win_sum.blue)  * PROD_W'(DIV_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_fire) begin
            m_window_valid_reg <= st2_win_ok_reg;
            m_mean_red_reg     <= st2_win_ok_reg ? prod_red[DIV_SHIFT +: CH_W]   : '0;
            m_mean_green_reg   <= st2_win_ok_reg ? prod_green[DIV_SHIFT +: CH_W] : '0;
            m_mean_blue_reg    <= st2_win_ok_reg ? prod_blue[DIV_SHIFT +: CH_W]  : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_valid = m_window_valid_reg;
    assign m_mean_red     = m_mean_red_reg;
    assign m_mean_green   = m_mean_green_reg;
    assign m_mean_blue    = m_mean_blue_reg;

    a_row_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg <= ROW_MAX)
        else $error("row count above saturation");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_valid |->
            m_mean_red == '0 && m_mean_green == '0 && m_mean_blue == '0)
        else $error("nonzero mean on invalid window");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !st1_fire |=> st1_valid_reg && $stable(st1_col_reg))
        else $error("stage 1 lost a held pixel");

endmodule

### bench/box_blur_5x5_rgb_top_tb.sv
// Self-checking bench for the 5x5 RGB box mean filter against a line-store predictor.
`timescale 1ns / 100ps

module box_blur_5x5_rgb_top_tb;
    import bbr_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS  = 1100;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            valid;
    } blur_result_t;

    class blur_scoreboard;
        pixel_t           line_mem [LINES][MAX_W];
        pixel_t           win [WIN][WIN];
        int unsigned      col_cnt;
        int unsigned      row_cnt;
        logic [CFG_W-1:0] width_reg;
        blur_result_t     expected_q [$];
        int               errors;

        function new();
            for (int r = 0; r < LINES; r++) begin
                for (int c = 0; c < MAX_W; c++) begin
                    line_mem[r][c] = '0;
                end
            end
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    win[r][c] = '0;
                end
            end
            col_cnt   = 0;
            row_cnt   = 0;
            width_reg = CFG_RESET;
            errors    = 0;
        endfunction

        function void set_width(logic [CFG_W-1:0] v);
            width_reg = v;
        endfunction

        function int effective_width();
            int w;
            w = width_reg;
            if (w < WIN) w = WIN;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(pixel_t px, logic fs);
            pixel_t       column [WIN];
            int unsigned  c;
            int unsigned  w;
            int           sum_r;
            int           sum_g;
            int           sum_b;
            blur_result_t res;
            w = effective_width();
            if (fs) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
            for (int r = 0; r < LINES; r++) column[r] = line_mem[r][c];
            column[WIN-1] = px;
            for (int r = 0; r < WIN; r++) begin
                for (int k = 0; k < WIN - 1; k++) win[r][k] = win[r][k+1];
                win[r][WIN-1] = column[r];
            end
            for (int r = 0; r < LINES; r++) line_mem[r][c] = column[r+1];
            res = '0;
            if (row_cnt >= LINES && c >= LINES) begin
                sum_r = 0;
                sum_g = 0;
                sum_b = 0;
                for (int r = 0; r < WIN; r++) begin
                    for (int k = 0; k < WIN; k++) begin
                        sum_r += win[r][k].red;
                        sum_g += win[r][k].green;
                        sum_b += win[r][k].blue;
                    end
                end
                res.red   = CH_W'(sum_r / (WIN * WIN));
                res.green = CH_W'(sum_g / (WIN * WIN));
                res.blue  = CH_W'(sum_b / (WIN * WIN));
                res.valid = 1'b1;
            end
            expected_q.push_back(res);
            if (c + 1 >= w) begin
                col_cnt = 0;
                if (row_cnt < LINES) row_cnt++;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void report_field(string name, int e, int a);
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
            errors++;
        endfunction

        function void check_result(blur_result_t got);
            blur_result_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.red !== exp_res.red) report_field("mean_red", exp_res.red, got.red);
            if (got.green !== exp_res.green) report_field("mean_green", exp_res.green, got.green);
            if (got.blue !== exp_res.blue) report_field("mean_blue", exp_res.blue, got.blue);
            if (got.valid !== exp_res.valid)
                report_field("window_valid", exp_res.valid, got.valid);
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_line_width = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CH_W-1:0]   s_red = '0;
    logic [CH_W-1:0]   s_green = '0;
    logic [CH_W-1:0]   s_blue = '0;
    logic              s_frame_start = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CH_W-1:0]   m_mean_red;
    logic [CH_W-1:0]   m_mean_green;
    logic [CH_W-1:0]   m_mean_blue;
    logic              m_window_valid;

    blur_scoreboard sb;
    bit             no_gaps = 1'b0;
    int             ready_hold = 0;
    int             idle_cycles = 0;

    box_blur_5x5_rgb_top #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_line_width (cfg_line_width),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mean_red     (m_mean_red),
        .m_mean_green   (m_mean_green),
        .m_mean_blue    (m_mean_blue),
        .m_window_valid (m_window_valid)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(pixel_t'{s_red, s_green, s_blue}, s_frame_start);
        if (aresetn && m_valid && m_ready)
            sb.check_result(blur_result_t'{m_mean_red, m_mean_green, m_mean_blue,
                                           m_window_valid});
    end

    // hold m_ready for random stretches: long ready runs, long stalls, short flicker
    always @(posedge aclk) begin
        int k;
        if (ready_hold == 0) begin
            k = $urandom_range(0, 99);
            if (k < 15) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(40, 150);
            end else if (k < 20) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end else if (k < 60) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("box_blur_5x5_rgb_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function int pick_gap();
        int k;
        if (no_gaps) return 0;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [CH_W-1:0] pick_channel();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                              logic fs);
        int gap;
        s_red         <= r;
        s_green       <= g;
        s_blue        <= b;
        s_frame_start <= fs;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_frame(int npix, bit with_start, bit noisy);
        logic fs;
        for (int i = 0; i < npix; i++) begin
            fs = (i == 0 && with_start) || (noisy && $urandom_range(0, 99) == 0);
            send_pixel(pick_channel(), pick_channel(), pick_channel(), fs);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_width(logic [CFG_W-1:0] v);
        drain_results();
        cfg_line_width <= v;
        cfg_valid      <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_width(v);
    endtask

    initial begin
        int               rand_items;
        int               iter;
        int               k;
        int               eff;
        int               rows;
        int               npix;
        bit               noisy;
        logic [CFG_W-1:0] wv;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_pixel('1, '0, '1, 1'b0);
        send_pixel('0, '1, '0, 1'b1);
        send_pixel('1, '1, '1, 1'b0);
        write_width('0);
        for (int i = 0; i < WIN * WIN; i++) send_pixel('1, '1, '1, i == 0);

        rand_items = 0;
        iter       = 0;
        while (rand_items < RAND_ITEMS) begin
            if (iter == 3) begin
                no_gaps = 1'b0;
                write_width('1);
                send_frame(WIN * WIN, 1'b1, 1'b0);
                rand_items += WIN * WIN;
            end else begin
                k = $urandom_range(0, 19);
                if (k < 14) wv = CFG_W'($urandom_range(5, 24));
                else if (k < 17) wv = CFG_W'($urandom_range(0, 4));
                else wv = CFG_W'($urandom_range(25, 64));
                write_width(wv);
                eff     = sb.effective_width();
                rows    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 8);
                noisy   = ($urandom_range(0, 7) == 0);
                no_gaps = ($urandom_range(0, 3) == 0);
                npix    = rows * eff + $urandom_range(0, eff - 1);
                send_frame(npix, 1'b1, noisy);
                rand_items += npix;
                // narrow the line mid-frame and carry on without a frame start
                if (!noisy && rows >= LINES && $urandom_range(0, 9) < 3) begin
                    write_width(CFG_W'($urandom_range(0, eff)));
                    npix = $urandom_range(1, 3) * sb.effective_width() + $urandom_range(0, 4);
                    send_frame(npix, 1'b0, 1'b0);
                    rand_items += npix;
                end
            end
            iter++;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("box_blur_5x5_rgb_top: match");
        end else begin
            $display("box_blur_5x5_rgb_top: mismatch");
        end
        $finish;
    end

endmodule
